// File: design/rpn_stack_alu_macros.svh
// Assertion helpers for the stack ALU top file.
`ifndef RPN_STACK_ALU_MACROS_SVH
`define RPN_STACK_ALU_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPN_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpn_stack_alu: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RPN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpn_stack_alu: next-cycle check failed");

`endif

// File: design/rpn_pkg.sv
`default_nettype none
package rpn_pkg;

   localparam int CMD_W         = 5;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int TOP_W         = 32;
   localparam int DEPTH_W       = 11;
   localparam int STACK_DEPTH_D = 1024;
   localparam int DATA_WIDTH_D  = 32;

   localparam logic [63:0] MASK_B8  = 64'h00ff00ff00ff00ff;
   localparam logic [63:0] MASK_B16 = 64'h0000ffff0000ffff;
   localparam logic [63:0] MASK_B32 = 64'h00000000ffffffff;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH    = 5'd0,
      CMD_ADD     = 5'd1,
      CMD_SUB     = 5'd2,
      CMD_MUL     = 5'd3,
      CMD_DIV     = 5'd4,
      CMD_MOD     = 5'd5,
      CMD_AND     = 5'd6,
      CMD_OR      = 5'd7,
      CMD_NAND    = 5'd8,
      CMD_NOR     = 5'd9,
      CMD_XOR     = 5'd10,
      CMD_XNOR    = 5'd11,
      CMD_SHL     = 5'd12,
      CMD_SHR     = 5'd13,
      CMD_NEG     = 5'd14,
      CMD_NOT     = 5'd15,
      CMD_SWAP    = 5'd16,
      CMD_SWAP16  = 5'd17,
      CMD_SWAP32  = 5'd18,
      CMD_FFS     = 5'd19,
      CMD_CLZ     = 5'd20,
      CMD_CTZ     = 5'd21,
      CMD_POPCNT  = 5'd22,
      CMD_ALL_ADD = 5'd23,
      CMD_ALL_MUL = 5'd24,
      CMD_ALL_OR  = 5'd25,
      CMD_ALL_AND = 5'd26,
      CMD_ALL_XOR = 5'd27
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_UNDERRUN = 2'd1,
      ST_OVERRUN  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CLS_PUSH,
      CLS_BIN,
      CLS_UNARY,
      CLS_FOLD,
      CLS_NOP
   } cls_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_BIN,
      S_MDWAIT,
      S_FOLD,
      S_FMUL,
      S_FIN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TOP_W-1:0]    top;
      logic [DEPTH_W-1:0]  depth;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       latch;
      logic       push;
      logic       unary;
      logic       binary;
      logic       rd_second;
      logic       rd_first;
      logic       rd_next;
      logic       md_start;
      logic       fold_init;
      logic       fold_step;
      logic       fold_finish;
      logic       rsp_valid;
      status_type status;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      cls_type cls;
      logic    is_md;
      logic    empty;
      logic    lt2;
      logic    full;
      logic    fold_last;
      logic    md_done;
   } sts_type;

   // byte reversal over spans of 16, 32 or 64 bits
   function automatic logic [63:0] byte_swap64(logic [63:0] v, int span);
      logic [63:0] r;
      r = v;
      if (span >= 64) r = ((r & MASK_B32) << 32) | ((r >> 32) & MASK_B32);
      if (span >= 32) r = ((r & MASK_B16) << 16) | ((r >> 16) & MASK_B16);
      if (span >= 16) r = ((r & MASK_B8) << 8) | ((r >> 8) & MASK_B8);
      return r;
   endfunction

endpackage
`default_nettype wire

// File: design/rpn_ram.sv
`default_nettype none
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: design/rpn_muldiv.sv
`default_nettype none
module rpn_muldiv #(
   parameter int W = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         op_div,
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   output logic              done,
   output logic      [W-1:0] prod,
   output logic      [W-1:0] quot,
   output logic      [W-1:0] rem
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          div_ff, div_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W:0]    acc_ff, acc_in;
   logic [W:0]    sh;

   // one bit per cycle: shift-add multiply or restoring divide
   // a zero divisor falls out as quotient all ones, remainder the dividend
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      sh      = {acc_ff[W-1:0], x_ff[W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         div_in  = op_div;
         x_in    = a;
         y_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (div_ff) begin
            x_in = {x_ff[W-2:0], 1'b0};
            if (sh >= {1'b0, y_ff}) begin
               acc_in  = sh - {1'b0, y_ff};
               x_in[0] = 1'b1;
            end else begin
               acc_in = sh;
            end
         end else begin
            if (y_ff[0]) acc_in = {1'b0, acc_ff[W-1:0] + x_ff};
            x_in = {x_ff[W-2:0], 1'b0};
            y_in = {1'b0, y_ff[W-1:1]};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff[W-1:0];
   assign quot = x_ff;
   assign rem  = acc_ff[W-1:0];

endmodule
`default_nettype wire

// File: design/rpn_ctrl.sv
`default_nettype none
module rpn_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire rpn_pkg::sts_type sts,
   output rpn_pkg::ctl_type      ctl
);

   rpn_pkg::state_type  state_ff, state_in;
   rpn_pkg::status_type status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rpn_pkg::S_IDLE;
         status_ff <= rpn_pkg::ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      ctl        = '0;
      ctl.status = status_ff;
      case (state_ff)
         rpn_pkg::S_IDLE: begin
            if (start) begin
               ctl.latch = 1'b1;
               state_in  = rpn_pkg::S_DECODE;
            end
         end
         rpn_pkg::S_DECODE: begin
            status_in = rpn_pkg::ST_OK;
            state_in  = rpn_pkg::S_RESP;
            case (sts.cls)
               rpn_pkg::CLS_PUSH: begin
                  if (sts.full) status_in = rpn_pkg::ST_OVERRUN;
                  else ctl.push = 1'b1;
               end
               rpn_pkg::CLS_BIN: begin
                  if (sts.lt2) begin
                     status_in = rpn_pkg::ST_UNDERRUN;
                  end else begin
                     ctl.rd_second = 1'b1;
                     state_in      = rpn_pkg::S_BIN;
                  end
               end
               rpn_pkg::CLS_UNARY: begin
                  if (sts.empty) status_in = rpn_pkg::ST_UNDERRUN;
                  else ctl.unary = 1'b1;
               end
               rpn_pkg::CLS_FOLD: begin
                  if (sts.lt2) begin
                     ctl.fold_finish = 1'b1;
                  end else begin
                     ctl.fold_init = 1'b1;
                     ctl.rd_first  = 1'b1;
                     state_in      = rpn_pkg::S_FOLD;
                  end
               end
               default: ;
            endcase
         end
         rpn_pkg::S_BIN: begin
            if (sts.is_md) begin
               ctl.md_start = 1'b1;
               state_in     = rpn_pkg::S_MDWAIT;
            end else begin
               ctl.binary = 1'b1;
               state_in   = rpn_pkg::S_RESP;
            end
         end
         rpn_pkg::S_MDWAIT: begin
            if (sts.md_done) begin
               ctl.binary = 1'b1;
               state_in   = rpn_pkg::S_RESP;
            end
         end
         rpn_pkg::S_FOLD: begin
            if (sts.is_md) begin
               ctl.md_start = 1'b1;
               state_in     = rpn_pkg::S_FMUL;
            end else begin
               ctl.fold_step = 1'b1;
               if (sts.fold_last) state_in = rpn_pkg::S_FIN;
               else ctl.rd_next = 1'b1;
            end
         end
         rpn_pkg::S_FMUL: begin
            if (sts.md_done) begin
               ctl.fold_step = 1'b1;
               if (sts.fold_last) begin
                  state_in = rpn_pkg::S_FIN;
               end else begin
                  ctl.rd_next = 1'b1;
                  state_in    = rpn_pkg::S_FOLD;
               end
            end
         end
         rpn_pkg::S_FIN: begin
            ctl.fold_finish = 1'b1;
            state_in        = rpn_pkg::S_RESP;
         end
         rpn_pkg::S_RESP: begin
            ctl.rsp_valid = 1'b1;
            state_in      = rpn_pkg::S_IDLE;
         end
         default: state_in = rpn_pkg::S_IDLE;
      endcase
   end

   assign busy = (state_ff != rpn_pkg::S_IDLE);

endmodule
`default_nettype wire

// File: design/rpn_dp.sv
`default_nettype none
module rpn_dp #(
   parameter int DW = 32,
   parameter int SD = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rpn_pkg::req_type req,
   input  wire rpn_pkg::ctl_type ctl,
   output rpn_pkg::sts_type      sts,
   output logic                  rsp_strobe,
   output rpn_pkg::rsp_type      rsp
);

   localparam int CNT_W = $clog2(SD + 1);
   localparam int AW    = $clog2(SD);
   localparam int SW    = $clog2(DW);
   localparam int CW    = $clog2(DW + 1);
   localparam int SPAN  = (DW > 32) ? 64 : 32;

   rpn_pkg::cmd_type cmd_ff;
   logic [DW-1:0]    val_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [DW-1:0]    top_ff, top_in;
   logic [DW-1:0]    acc_ff, acc_in;

   logic [DW-1:0]    rd_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;

   logic             md_done;
   logic [DW-1:0]    md_prod, md_quot, md_rem;
   logic             is_fold;
   logic             is_divmod;

   logic [DW-1:0]    bin_res, una_res, fold_res, ident;
   logic [CW-1:0]    ctz, clz, pop;

   // entries below the top of stack live in memory; the top is a register
   assign wr_en   = ctl.push && (count_ff != '0);
   assign rd_en   = ctl.rd_second || ctl.rd_first || ctl.rd_next;
   assign rd_addr = ctl.rd_second ? AW'(count_ff - CNT_W'(2)) :
                    ctl.rd_first  ? '0 : AW'(idx_ff);

   rpn_ram #(.WIDTH(DW), .DEPTH(SD)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(count_ff - CNT_W'(1))),
      .wr_data (top_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign is_fold   = (cmd_ff inside {[rpn_pkg::CMD_ALL_ADD:rpn_pkg::CMD_ALL_XOR]});
   assign is_divmod = (cmd_ff == rpn_pkg::CMD_DIV) || (cmd_ff == rpn_pkg::CMD_MOD);

   rpn_muldiv #(.W(DW)) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (ctl.md_start),
      .op_div (is_divmod),
      .a      (is_fold ? acc_ff : rd_data),
      .b      (is_fold ? rd_data : top_ff),
      .done   (md_done),
      .prod   (md_prod),
      .quot   (md_quot),
      .rem    (md_rem)
   );

   // status toward the controller
   always_comb begin
      if (cmd_ff == rpn_pkg::CMD_PUSH) sts.cls = rpn_pkg::CLS_PUSH;
      else if (cmd_ff inside {[rpn_pkg::CMD_ADD:rpn_pkg::CMD_SHR]}) sts.cls = rpn_pkg::CLS_BIN;
      else if (cmd_ff inside {[rpn_pkg::CMD_NEG:rpn_pkg::CMD_POPCNT]})
         sts.cls = rpn_pkg::CLS_UNARY;
      else if (is_fold) sts.cls = rpn_pkg::CLS_FOLD;
      else sts.cls = rpn_pkg::CLS_NOP;
      sts.is_md     = (cmd_ff inside {rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD,
                                      rpn_pkg::CMD_ALL_MUL});
      sts.empty     = (count_ff == '0);
      sts.lt2       = (count_ff < CNT_W'(2));
      sts.full      = (count_ff == CNT_W'(SD));
      sts.fold_last = (idx_ff == count_ff - CNT_W'(1));
      sts.md_done   = md_done;
   end

   // binary ops: a is the entry below the top, b is the top
   always_comb begin
      case (cmd_ff)
         rpn_pkg::CMD_ADD:  bin_res = rd_data + top_ff;
         rpn_pkg::CMD_SUB:  bin_res = rd_data - top_ff;
         rpn_pkg::CMD_MUL:  bin_res = md_prod;
         rpn_pkg::CMD_DIV:  bin_res = md_quot;
         rpn_pkg::CMD_MOD:  bin_res = md_rem;
         rpn_pkg::CMD_AND:  bin_res = rd_data & top_ff;
         rpn_pkg::CMD_OR:   bin_res = rd_data | top_ff;
         rpn_pkg::CMD_NAND: bin_res = ~(rd_data & top_ff);
         rpn_pkg::CMD_NOR:  bin_res = ~(rd_data | top_ff);
         rpn_pkg::CMD_XOR:  bin_res = rd_data ^ top_ff;
         rpn_pkg::CMD_XNOR: bin_res = ~(rd_data ^ top_ff);
         rpn_pkg::CMD_SHL:
            bin_res = (top_ff >= DW'(DW)) ? '0 : (rd_data << top_ff[SW-1:0]);
         default:
            bin_res = (top_ff >= DW'(DW)) ? '0 : (rd_data >> top_ff[SW-1:0]);
      endcase
   end

   // bit counts of the top entry
   always_comb begin
      ctz = CW'(DW);
      clz = CW'(DW);
      pop = '0;
      for (int i = DW - 1; i >= 0; i--) begin
         if (top_ff[i]) ctz = CW'(i);
      end
      for (int i = 0; i < DW; i++) begin
         if (top_ff[i]) clz = CW'(DW - 1 - i);
         pop = pop + CW'(top_ff[i]);
      end
   end

   // unary ops on the top
   always_comb begin
      case (cmd_ff)
         rpn_pkg::CMD_NEG:    una_res = '0 - top_ff;
         rpn_pkg::CMD_NOT:    una_res = ~top_ff;
         rpn_pkg::CMD_SWAP:   una_res = DW'(rpn_pkg::byte_swap64(64'(top_ff), SPAN));
         rpn_pkg::CMD_SWAP16: una_res = DW'(rpn_pkg::byte_swap64(64'(top_ff), 16));
         rpn_pkg::CMD_SWAP32: una_res = DW'(rpn_pkg::byte_swap64(64'(top_ff), 32));
         rpn_pkg::CMD_FFS:    una_res = (top_ff == '0) ? '0 : DW'(ctz) + DW'(1);
         rpn_pkg::CMD_CLZ:    una_res = DW'(clz);
         rpn_pkg::CMD_CTZ:    una_res = DW'(ctz);
         default:             una_res = DW'(pop);
      endcase
   end

   // reduction step and identity of each reduction
   always_comb begin
      case (cmd_ff)
         rpn_pkg::CMD_ALL_ADD: fold_res = acc_ff + rd_data;
         rpn_pkg::CMD_ALL_MUL: fold_res = md_prod;
         rpn_pkg::CMD_ALL_OR:  fold_res = acc_ff | rd_data;
         rpn_pkg::CMD_ALL_AND: fold_res = acc_ff & rd_data;
         default:              fold_res = acc_ff ^ rd_data;
      endcase
      case (cmd_ff)
         rpn_pkg::CMD_ALL_MUL: ident = DW'(1);
         rpn_pkg::CMD_ALL_AND: ident = '1;
         default:              ident = '0;
      endcase
   end

   // stack state update
   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      acc_in   = acc_ff;
      idx_in   = idx_ff;
      if (ctl.push) begin
         top_in   = val_ff;
         count_in = count_ff + CNT_W'(1);
      end
      if (ctl.unary) top_in = una_res;
      if (ctl.binary) begin
         top_in   = bin_res;
         count_in = count_ff - CNT_W'(1);
      end
      if (ctl.fold_init) acc_in = top_ff;
      if (ctl.fold_step) acc_in = fold_res;
      if (ctl.rd_first) idx_in = CNT_W'(1);
      if (ctl.rd_next) idx_in = idx_ff + CNT_W'(1);
      if (ctl.fold_finish) begin
         if (count_ff == '0) top_in = ident;
         else if (count_ff != CNT_W'(1)) top_in = acc_ff;
         count_in = CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      top_ff <= top_in;
      acc_ff <= acc_in;
      idx_ff <= idx_in;
      if (ctl.latch) begin
         cmd_ff <= rpn_pkg::cmd_type'(req.command);
         val_ff <= DW'(req.value);
      end
   end

   // result transfer
   assign rsp_strobe = ctl.rsp_valid;
   assign rsp.status = ctl.status;
   assign rsp.top    = (count_ff == '0) ? '0 : rpn_pkg::TOP_W'(top_ff);
   assign rsp.depth  = rpn_pkg::DEPTH_W'(count_ff);

endmodule
`default_nettype wire

// File: design/rpn_stack_alu.sv
// Each command passes from decode to the result state; binary ops first read the
// entry below the top, and mul/div/mod wait on the shared multiply/divide unit (one
// bit per cycle); busy clears the cycle after the strobe.
// Pop-all folds one stack entry per cycle, except all_mul, which waits on the
// multiply unit for each entry; with two or more entries a finish state ends the fold.
// Synchronous active-high reset empties the stack; memory is not cleared; no stall.
`default_nettype none
`include "rpn_stack_alu_macros.svh"
module rpn_stack_alu #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_D,
   parameter int DATA_WIDTH  = rpn_pkg::DATA_WIDTH_D
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire rpn_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output rpn_pkg::rsp_type      rsp_data
);

   rpn_pkg::ctl_type ctl;
   rpn_pkg::sts_type sts;

   rpn_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   rpn_dp #(.DW(DATA_WIDTH), .SD(STACK_DEPTH)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req        (req_data),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

   // an accepted command keeps the block busy until its result transfer
   `RPN_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_strobe)
   // after a result transfer the block is ready again
   `RPN_ASSERT_NEXT(a_rsp_idle, clock, reset, rsp_strobe, !busy)
   // overrun only on a full stack
   `RPN_ASSERT_NOW(a_overrun_full, clock, reset, rsp_strobe && (rsp_data.status == rpn_pkg::ST_OVERRUN), rsp_data.depth == rpn_pkg::DEPTH_W'(STACK_DEPTH))

endmodule
`default_nettype wire
